/* rtl/bicycle_trajectory_projector_top_defines.svh */
// Assertion macros for the bicycle trajectory projector RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BICYCLE_TRAJECTORY_PROJECTOR_TOP_DEFINES_SVH
`define BICYCLE_TRAJECTORY_PROJECTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define BTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BTP_ASSERT_NOW(lbl, ante, cons, msg)
`define BTP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/btp_pkg.sv */
// Shared types, constants and tables for the bicycle trajectory projector.
// No dependencies.
`timescale 1ns / 1ps
package btp_pkg;
    localparam int MAX_STEPS_DEF   = 63;
    localparam int CORDIC_ITER_DEF = 16;

    localparam logic [29:0] CORDIC_GAIN   = 30'd652032874;
    localparam logic [30:0] INV_TWO_PI    = 31'd683565276;
    localparam logic signed [15:0] STEER_LIMIT = 16'sd15000;

    localparam logic [15:0] WHEELBASE_RST  = 16'd84;
    localparam logic [15:0] STEP_TIME_RST  = 16'd6554;
    localparam logic [5:0]  STEP_COUNT_RST = 6'd10;

    localparam logic [1:0] REG_WHEELBASE  = 2'd0;
    localparam logic [1:0] REG_STEP_TIME  = 2'd1;
    localparam logic [1:0] REG_STEP_COUNT = 2'd2;

    localparam int CW = 34;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EMIT, ST_SC_GO, ST_SC_WAIT, ST_MUL_A, ST_MUL_B, ST_DIV_GO,
        ST_DIV_WAIT, ST_MUL_C, ST_HSTEP, ST_PC_GO, ST_PC_WAIT, ST_PMUL_A,
        ST_PMUL_B, ST_UPDATE
    } state_t;

    typedef struct packed {
        logic load;
        logic emit;
        logic cordic_steer;
        logic cordic_head;
        logic mul_a;
        logic mul_b;
        logic div_start;
        logic mul_c;
        logic hstep;
        logic pmul_a;
        logic pmul_b;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic is_last;
        logic at_start;
        logic cordic_done;
        logic div_done;
    } status_t;

    function automatic logic [29:0] atan_entry(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            default: r = 30'd0;
        endcase
        return r;
    endfunction
endpackage

/* rtl/bicycle_trajectory_projector_top.sv */
// channel   | valid / ready       | payload
// input     | s_tvalid / s_tready | s_tdata: start pose, speed, steering
// result    | m_tvalid / m_tready | m_tdata: point, m_tlast: last point
// config    | cfg_wr_en           | cfg_index, cfg_wdata
// One item per trajectory; after accept the controller enters emit, which registers the start point.
// Steering setup after the start point: steering CORDIC, multiplies, divider, heading-step multiply.
// Each Euler step: heading CORDIC on the shared CORDIC, position multiplies, update, then its emit.
// A new item is accepted only in idle, after the last point of the previous one is emitted.
// Reset aresetn is synchronous; a stalled m_tready holds the controller at emit.
// Top level of the bicycle trajectory projector; depends on btp_pkg,
// btp_ctrl and btp_datapath.
`timescale 1ns / 1ps
module bicycle_trajectory_projector_top #(
    parameter int MAX_STEPS         = btp_pkg::MAX_STEPS_DEF,
    parameter int CORDIC_ITERATIONS = btp_pkg::CORDIC_ITER_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_x, start_y, start_heading, speed, steer_angle
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // step_index, pos_x, pos_y, heading, 2 zero pad bits
    output logic [87:0]  m_tdata,
    output logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);
    btp_pkg::cmd_t    cmd;
    btp_pkg::status_t st;

    btp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    btp_datapath #(
        .MAX_STEPS         (MAX_STEPS),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );
endmodule

/* rtl/btp_cordic.sv */
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on btp_pkg (arctangent table, gain, widths).
`timescale 1ns / 1ps
module btp_cordic #(
    parameter int ITER = btp_pkg::CORDIC_ITER_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [31:0]                  angle,
    output logic                         done,
    output logic signed [btp_pkg::CW-1:0] cos_o,
    output logic signed [btp_pkg::CW-1:0] sin_o
);
    localparam int CW  = btp_pkg::CW;
    localparam int ITW = $clog2(ITER);

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] x_next, y_next, z_next, atan_v, z0;
    logic                 flip_reg, flip_next;
    logic                 busy_reg, done_reg;
    logic [ITW-1:0]       cnt_reg;

    always_comb begin
        z0 = CW'(signed'(angle));
        flip_next = 1'b0;
        if (z0 > CW'(64'sd1073741824)) begin
            z0 = z0 - CW'(64'sd2147483648);
            flip_next = 1'b1;
        end else if (z0 < -CW'(64'sd1073741824)) begin
            z0 = z0 + CW'(64'sd2147483648);
            flip_next = 1'b1;
        end
    end

    always_comb begin
        atan_v = CW'(btp_pkg::atan_entry(5'(cnt_reg)));
        if (!z_reg[CW-1]) begin
            x_next = x_reg - (y_reg >>> cnt_reg);
            y_next = y_reg + (x_reg >>> cnt_reg);
            z_next = z_reg - atan_v;
        end else begin
            x_next = x_reg + (y_reg >>> cnt_reg);
            y_next = y_reg - (x_reg >>> cnt_reg);
            z_next = z_reg + atan_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ITW'(ITER - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= CW'(btp_pkg::CORDIC_GAIN);
            y_reg    <= '0;
            z_reg    <= z0;
            flip_reg <= flip_next;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign done  = done_reg;
    assign cos_o = flip_reg ? -x_reg : x_reg;
    assign sin_o = flip_reg ? -y_reg : y_reg;
endmodule

/* rtl/btp_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// No package dependencies.
`timescale 1ns / 1ps
module btp_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [38:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] dvd_reg;
    logic [39:0] rem_reg, rem_sh;
    logic [38:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg, done_reg, bit_q;
    logic [39:0] rem_next;

    always_comb begin
        rem_sh = {rem_reg[38:0], dvd_reg[63]};
        bit_q  = rem_sh >= {1'b0, den_reg};
        rem_next = bit_q ? rem_sh - {1'b0, den_reg} : rem_sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[62:0], bit_q};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;
endmodule

/* rtl/btp_datapath.sv */
// Datapath: registers, multipliers, CORDIC, divider and the output register.
// Depends on btp_pkg, btp_cordic and btp_div.
`timescale 1ns / 1ps
module btp_datapath #(
    parameter int MAX_STEPS         = btp_pkg::MAX_STEPS_DEF,
    parameter int CORDIC_ITERATIONS = btp_pkg::CORDIC_ITER_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  btp_pkg::cmd_t     cmd,
    output btp_pkg::status_t  st,
    input  logic [111:0]      s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [87:0]       m_tdata,
    output logic              m_tlast,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_wdata
);
    localparam int CW = btp_pkg::CW;

    logic [15:0] wb_reg, dt_reg;
    logic [5:0]  sc_reg;

    logic signed [31:0] x_reg, y_reg;
    logic [23:0]        hacc_reg, hstep_reg;
    logic [5:0]         cnt_reg, n_reg;
    logic signed [15:0] v_reg, steer_reg;

    logic signed [39:0] num1_reg;
    logic [38:0]        den_reg;
    logic signed [63:0] num_reg;
    logic signed [66:0] p_reg;
    logic signed [49:0] vc_reg, vs_reg;
    logic signed [66:0] pdx_reg, pdy_reg;

    logic [87:0] out_data_reg;
    logic        out_valid_reg, out_last_reg;

    logic signed [15:0] s_in, stc;
    logic [5:0]         n_next;
    logic [31:0]        cordic_angle;
    logic               cordic_start, cordic_done, div_done;
    logic signed [CW-1:0] cos_v, sin_v;
    logic signed [23:0] s22, c22;
    logic [22:0]        c22u;
    logic [15:0]        wb_eff;
    logic               neg;
    logic [63:0]        mag, quo;
    logic [33:0]        qm;
    logic signed [34:0] qs;
    logic signed [66:0] p_rnd;
    logic signed [34:0] hs_w;
    logic [23:0]        hs;
    logic signed [31:0] x_next, y_next;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
                                                  input logic signed [66:0] prod);
        logic signed [66:0] d;
        logic signed [33:0] r;
        d = (prod + 67'sd137438953472) >>> 38;
        r = 34'(base) + 34'(d);
        if (r > 34'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (r < -34'sd2147483648)
            return 32'sh80000000;
        return 32'(r);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_reg <= btp_pkg::WHEELBASE_RST;
            dt_reg <= btp_pkg::STEP_TIME_RST;
            sc_reg <= btp_pkg::STEP_COUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                btp_pkg::REG_WHEELBASE:  wb_reg <= cfg_wdata;
                btp_pkg::REG_STEP_TIME:  dt_reg <= cfg_wdata;
                btp_pkg::REG_STEP_COUNT: sc_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        s_in = signed'(s_tdata[111:96]);
        if (s_in > btp_pkg::STEER_LIMIT)
            stc = btp_pkg::STEER_LIMIT;
        else if (s_in < -btp_pkg::STEER_LIMIT)
            stc = -btp_pkg::STEER_LIMIT;
        else
            stc = s_in;
        n_next = (sc_reg > 6'(MAX_STEPS)) ? 6'(MAX_STEPS) : sc_reg;
    end

    assign cordic_start = cmd.cordic_steer | cmd.cordic_head;
    assign cordic_angle = cmd.cordic_steer ? {steer_reg, 16'd0} : {hacc_reg, 8'd0};

    btp_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .angle   (cordic_angle),
        .done    (cordic_done),
        .cos_o   (cos_v),
        .sin_o   (sin_v)
    );

    always_comb begin
        s22    = 24'(sin_v >>> 8);
        c22    = 24'(cos_v >>> 8);
        c22u   = (c22 < 24'sd1) ? 23'd1 : c22[22:0];
        wb_eff = (wb_reg == 16'd0) ? 16'd1 : wb_reg;
        neg    = num_reg[63];
        mag    = neg ? 64'(-num_reg) : 64'(num_reg);
        qm     = (quo > 64'd8589934592) ? 34'd8589934592 : quo[33:0];
        qs     = neg ? -signed'({1'b0, qm}) : signed'({1'b0, qm});
        p_rnd  = p_reg + 67'sd2147483648;
        hs_w   = 35'(p_rnd >>> 32);
        if (hs_w > 35'sd8388607)
            hs = 24'h7FFFFF;
        else if (hs_w < -35'sd8388608)
            hs = 24'h800000;
        else
            hs = hs_w[23:0];
        x_next = sat_add(x_reg, pdx_reg);
        y_next = sat_add(y_reg, pdy_reg);
    end

    btp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (mag),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            n_reg   <= '0;
        end else if (cmd.load) begin
            cnt_reg <= '0;
            n_reg   <= n_next;
        end else if (cmd.update) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg     <= signed'(s_tdata[31:0]);
            y_reg     <= signed'(s_tdata[63:32]);
            hacc_reg  <= {s_tdata[79:64], 8'd0};
            v_reg     <= signed'(s_tdata[95:80]);
            steer_reg <= stc;
        end
        if (cmd.mul_a) begin
            num1_reg <= v_reg * s22;
            den_reg  <= c22u * wb_eff;
        end
        if (cmd.mul_b)
            num_reg <= (num1_reg * signed'({1'b0, dt_reg})) <<< 8;
        if (cmd.mul_c)
            p_reg <= qs * signed'({1'b0, btp_pkg::INV_TWO_PI});
        if (cmd.hstep)
            hstep_reg <= hs;
        if (cmd.pmul_a) begin
            vc_reg <= v_reg * cos_v;
            vs_reg <= v_reg * sin_v;
        end
        if (cmd.pmul_b) begin
            pdx_reg <= vc_reg * signed'({1'b0, dt_reg});
            pdy_reg <= vs_reg * signed'({1'b0, dt_reg});
        end
        if (cmd.update) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            hacc_reg <= hacc_reg + hstep_reg;
        end
        if (cmd.emit) begin
            out_data_reg <= {2'b00, hacc_reg[23:8], y_reg, x_reg, cnt_reg};
            out_last_reg <= (cnt_reg == n_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign st.out_free    = !out_valid_reg || m_tready;
    assign st.is_last     = (cnt_reg == n_reg);
    assign st.at_start    = (cnt_reg == 6'd0);
    assign st.cordic_done = cordic_done;
    assign st.div_done    = div_done;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
endmodule

/* rtl/btp_ctrl.sv */
// Controller state machine sequencing setup, steering math and Euler steps.
// Depends on btp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bicycle_trajectory_projector_top_defines.svh"
module btp_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  btp_pkg::status_t st,
    output btp_pkg::cmd_t    cmd
);
    btp_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= btp_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            btp_pkg::ST_IDLE:     if (s_tvalid) state_next = btp_pkg::ST_EMIT;
            btp_pkg::ST_EMIT: begin
                if (st.out_free) begin
                    if (st.is_last)
                        state_next = btp_pkg::ST_IDLE;
                    else if (st.at_start)
                        state_next = btp_pkg::ST_SC_GO;
                    else
                        state_next = btp_pkg::ST_PC_GO;
                end
            end
            btp_pkg::ST_SC_GO:    state_next = btp_pkg::ST_SC_WAIT;
            btp_pkg::ST_SC_WAIT:  if (st.cordic_done) state_next = btp_pkg::ST_MUL_A;
            btp_pkg::ST_MUL_A:    state_next = btp_pkg::ST_MUL_B;
            btp_pkg::ST_MUL_B:    state_next = btp_pkg::ST_DIV_GO;
            btp_pkg::ST_DIV_GO:   state_next = btp_pkg::ST_DIV_WAIT;
            btp_pkg::ST_DIV_WAIT: if (st.div_done) state_next = btp_pkg::ST_MUL_C;
            btp_pkg::ST_MUL_C:    state_next = btp_pkg::ST_HSTEP;
            btp_pkg::ST_HSTEP:    state_next = btp_pkg::ST_PC_GO;
            btp_pkg::ST_PC_GO:    state_next = btp_pkg::ST_PC_WAIT;
            btp_pkg::ST_PC_WAIT:  if (st.cordic_done) state_next = btp_pkg::ST_PMUL_A;
            btp_pkg::ST_PMUL_A:   state_next = btp_pkg::ST_PMUL_B;
            btp_pkg::ST_PMUL_B:   state_next = btp_pkg::ST_UPDATE;
            btp_pkg::ST_UPDATE:   state_next = btp_pkg::ST_EMIT;
            default:              state_next = btp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            btp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            btp_pkg::ST_EMIT:    cmd.emit = st.out_free;
            btp_pkg::ST_SC_GO:   cmd.cordic_steer = 1'b1;
            btp_pkg::ST_MUL_A:   cmd.mul_a = 1'b1;
            btp_pkg::ST_MUL_B:   cmd.mul_b = 1'b1;
            btp_pkg::ST_DIV_GO:  cmd.div_start = 1'b1;
            btp_pkg::ST_MUL_C:   cmd.mul_c = 1'b1;
            btp_pkg::ST_HSTEP:   cmd.hstep = 1'b1;
            btp_pkg::ST_PC_GO:   cmd.cordic_head = 1'b1;
            btp_pkg::ST_PMUL_A:  cmd.pmul_a = 1'b1;
            btp_pkg::ST_PMUL_B:  cmd.pmul_b = 1'b1;
            btp_pkg::ST_UPDATE:  cmd.update = 1'b1;
            default: ;
        endcase
    end

    `BTP_ASSERT_NOW(a_emit_free, cmd.emit, st.out_free, "item emitted over a pending result")
    `BTP_ASSERT_NOW(a_div_done_wait, st.div_done, state_reg == btp_pkg::ST_DIV_WAIT,
                    "divider finished outside its wait state")
    `BTP_ASSERT_NEXT(a_load_emit, cmd.load, state_reg == btp_pkg::ST_EMIT,
                     "accepted item did not go to emit start point")
endmodule
